>>> design/arp_pkg.sv
// Shared types, sizes and codes for the adaptive replacement policy block.
`timescale 1ns / 1ps
package arp_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int AGE_W     = 16;
  localparam int SUM_W     = 17;
  localparam int CAP_W     = 16;
  localparam int UNIT_W    = 8;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd64;
  localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;

  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_MISS   = 3'd1;
  localparam logic [2:0] KIND_RGHOST = 3'd2;
  localparam logic [2:0] KIND_FGHOST = 3'd3;
  localparam logic [2:0] KIND_FAIL   = 3'd4;
  localparam logic [2:0] KIND_FULL   = 3'd5;
  localparam logic [2:0] KIND_DEMOTE = 3'd6;
  localparam logic [2:0] KIND_DROP   = 3'd7;

  localparam logic [1:0] LIST_RECENT = 2'd0;
  localparam logic [1:0] LIST_FREQ   = 2'd1;
  localparam logic [1:0] LIST_RGHOST = 2'd2;
  localparam logic [1:0] LIST_FGHOST = 2'd3;

  typedef enum logic [1:0] {
    SCAN_KEY,
    SCAN_FREE,
    SCAN_LRU
  } scan_mode_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] tag;
    logic [UNIT_W-1:0]   units;
    logic [1:0]          list;
    logic [AGE_W-1:0]    age;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [AGE_W-1:0] age;
  } scan_t;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    entry_t              wr_entry;
    logic                rank_clr;
    logic                rank_step;
    logic                bc_valid;
    logic [AGE_W-1:0]    bc_age;
    logic                rank_commit;
    scan_mode_t          mode;
    logic [1:0]          list;
    logic [KEY_BITS-1:0] key;
  } cell_cmd_t;

endpackage

>>> design/arp_cell.sv
// One table slot: holds an entry and passes the running scan result to its neighbour.
`timescale 1ns / 1ps
module arp_cell
  import arp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_idx,
  input  cell_cmd_t        cmd,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  output entry_t           entry
);

  logic                valid;
  logic [KEY_BITS-1:0] tag;
  logic [UNIT_W-1:0]   units;
  logic [1:0]          list;
  logic [AGE_W-1:0]    age;
  logic [IDX_W-1:0]    rank;
  logic                take;

  assign entry = '{valid: valid, tag: tag, units: units, list: list, age: age};

  always_comb begin
    case (cmd.mode)
      SCAN_KEY:  take = !scan_in.hit && valid && (tag == cmd.key);
      SCAN_FREE: take = !scan_in.hit && !valid;
      SCAN_LRU:  take = valid && (list == cmd.list) && (!scan_in.hit || age < scan_in.age);
      default:   take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    scan_out <= take ? scan_t'{hit: 1'b1, idx: my_idx, age: age} : scan_in;
    if (cmd.rank_clr) begin
      rank <= '0;
    end else if (cmd.rank_step && cmd.bc_valid && (cmd.bc_age < age)) begin
      rank <= rank + 1'b1;
    end
    if (cmd.wr_en && (cmd.wr_idx == my_idx)) begin
      tag   <= cmd.wr_entry.tag;
      units <= cmd.wr_entry.units;
      list  <= cmd.wr_entry.list;
      age   <= cmd.wr_entry.age;
    end else if (cmd.rank_commit && valid) begin
      age <= AGE_W'(rank);
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.wr_en && (cmd.wr_idx == my_idx)) begin
      valid <= cmd.wr_entry.valid;
    end
  end

endmodule

>>> design/arp_div.sv
// Restoring divider for the ghost list size ratio, one quotient bit per cycle.
`timescale 1ns / 1ps
module arp_div
  import arp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [SUM_W-1:0] quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W:0]       rem;
  logic [SUM_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem[SUM_W-1:0], quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SUM_W);
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? rem_sh - {1'b0, den} : rem_sh;
        quo <= {quo[SUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/adaptive_replacement_policy.sv
// Top level: request sequencer, list sums and target, over a chain of table cells.
//
// Input channel: key, object_size, fetch_fails with in_valid/in_stall. One
// request is taken at a time; in_stall stays high from acceptance until the
// final result beat of that request has been loaded into the output register.
// Output channel: kind, entry_key, entry_size, target_recent, last with
// out_valid/out_stall. Each request gives zero or more notice beats (demoted,
// dropped) followed by one final beat with last set. A single output register
// holds each beat; while out_stall is high the sequencer waits on it.
// Each table search ripples through the chain of ENTRIES cells. A ghost hit waits
// on the ratio divider before the target is adapted. The next request is taken
// the cycle after the final beat is loaded. When the age counter reaches its
// maximum, the ages are renumbered and the counter restarts from the number of
// valid entries. The user must write capacity through capacity_we/capacity_wdata
// only while idle; the block itself does not enforce it. A write also reloads the
// target to half its value.
// Reset (rst, synchronous) empties the table, clears the list sums and age
// counter, sets capacity to 64 and the target to 32.
`timescale 1ns / 1ps
module adaptive_replacement_policy
  import arp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       key,
  input  logic [7:0]        object_size,
  input  logic              fetch_fails,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [31:0]       entry_key,
  output logic [7:0]        entry_size,
  output logic [15:0]       target_recent,
  output logic              last,
  input  logic              capacity_we,
  input  logic [CAP_W-1:0]  capacity_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_SEARCHED, S_HIT_RES, S_DIV, S_GHOST_ADAPT, S_BAL1,
    S_BAL1_GOT, S_BAL2, S_BAL2_GOT, S_FREE_START, S_FREE_GOT, S_GHOST_FIN,
    S_TOUCH, S_RN_CLR, S_RN_STEP, S_RN_COMMIT, S_NOTE, S_FINAL
  } state_t;

  state_t              state;
  state_t              scan_ret;
  state_t              bal_ret;
  state_t              touch_ret;
  logic [CNT_W-1:0]    cnt;
  scan_mode_t          scan_mode;
  logic [1:0]          scan_list;
  logic                found;
  logic [IDX_W-1:0]    cur_idx;
  logic [IDX_W-1:0]    hit_idx;
  logic [KEY_BITS-1:0] req_key;
  logic [UNIT_W-1:0]   req_size;
  logic                req_fails;
  logic [1:0]          hit_list;
  logic [UNIT_W-1:0]   hit_units;
  logic [UNIT_W-1:0]   bal_size;
  logic [SUM_W-1:0]    list_sums [4];
  logic [CAP_W-1:0]    target_p;
  logic [CAP_W-1:0]    capacity;
  logic [AGE_W-1:0]    age_counter;
  logic [2:0]          note_kind;
  logic [KEY_BITS-1:0] note_key;
  logic [UNIT_W-1:0]   note_size;
  logic [2:0]          fin_kind;
  logic [UNIT_W-1:0]   fin_size;
  logic [CNT_W-1:0]    rn_j;
  logic [CNT_W-1:0]    rn_n;
  logic                div_start;

  cell_cmd_t           cmd;
  scan_t               chain [ENTRIES+1];
  entry_t              ents [ENTRIES];
  entry_t              cur_e;
  entry_t              bc_e;
  logic                out_free;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [SUM_W-1:0]    div_num;
  logic [SUM_W-1:0]    div_den;
  logic [SUM_W-1:0]    ratio;
  logic [SUM_W:0]      p_sum;
  logic [SUM_W:0]      res_total;
  logic [SUM_W:0]      ghost_total;

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (IDX_W'(g)),
      .cmd      (cmd),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1]),
      .entry    (ents[g])
    );
  end

  assign div_num = (hit_list == LIST_RGHOST) ? list_sums[3] : list_sums[2];
  assign div_den = (hit_list == LIST_RGHOST) ? list_sums[2] : list_sums[3];

  arp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cur_e       = ents[cur_idx];
  assign bc_e        = ents[rn_j[IDX_W-1:0]];
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);
  assign res_total   = {1'b0, list_sums[0]} + {1'b0, list_sums[1]} + (SUM_W+1)'(bal_size);
  assign ghost_total = {1'b0, list_sums[2]} + {1'b0, list_sums[3]};

  // ratio of ghost sums, zero divisor counts as zero, floored at one
  always_comb begin
    ratio = (div_den == '0) ? '0 : div_quo;
    if (ratio == '0) begin
      ratio = SUM_W'(1);
    end
    p_sum = (SUM_W+1)'(target_p) + (SUM_W+1)'(ratio);
  end

  always_comb begin
    cmd          = '0;
    cmd.mode     = scan_mode;
    cmd.list     = scan_list;
    cmd.key      = req_key;
    cmd.wr_idx   = cur_idx;
    cmd.wr_entry = cur_e;
    cmd.bc_valid = bc_e.valid;
    cmd.bc_age   = bc_e.age;
    case (state)
      S_HIT_RES: begin
        cmd.wr_en         = 1'b1;
        cmd.wr_entry.list = LIST_FREQ;
      end
      S_GHOST_ADAPT: begin
        cmd.wr_en          = 1'b1;
        cmd.wr_entry.valid = 1'b0;
      end
      S_BAL1_GOT: begin
        cmd.wr_en         = found;
        cmd.wr_entry.list = cur_e.list + 2'd2;
      end
      S_BAL2_GOT: begin
        cmd.wr_en          = found;
        cmd.wr_entry.valid = 1'b0;
      end
      S_FREE_GOT: begin
        cmd.wr_en    = found && !req_fails;
        cmd.wr_entry = '{valid: 1'b1, tag: req_key, units: req_size,
                         list: LIST_RECENT, age: age_counter};
      end
      S_GHOST_FIN: begin
        cmd.wr_en          = 1'b1;
        cmd.wr_entry.valid = 1'b1;
        cmd.wr_entry.list  = req_fails ? hit_list : LIST_FREQ;
      end
      S_TOUCH: begin
        cmd.wr_en        = (age_counter != AGE_MAX);
        cmd.wr_entry.age = age_counter;
      end
      S_RN_CLR:    cmd.rank_clr    = 1'b1;
      S_RN_STEP:   cmd.rank_step   = 1'b1;
      S_RN_COMMIT: cmd.rank_commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      capacity     <= CAP_RESET;
      target_p     <= CAP_RESET >> 1;
      age_counter  <= '0;
      list_sums[0] <= '0;
      list_sums[1] <= '0;
      list_sums[2] <= '0;
      list_sums[3] <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (capacity_we) begin
        capacity <= capacity_wdata;
        target_p <= capacity_wdata >> 1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_key   <= key[KEY_BITS-1:0];
            req_size  <= (object_size == '0) ? UNIT_W'(1) : object_size;
            req_fails <= fetch_fails;
            scan_mode <= SCAN_KEY;
            cnt       <= '0;
            scan_ret  <= S_SEARCHED;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ENTRIES)) begin
            found   <= chain[ENTRIES].hit;
            cur_idx <= chain[ENTRIES].idx;
            state   <= scan_ret;
          end
        end
        S_SEARCHED: begin
          hit_list  <= cur_e.list;
          hit_units <= cur_e.units;
          hit_idx   <= cur_idx;
          if (!found) begin
            bal_size <= req_size;
            bal_ret  <= S_FREE_START;
            state    <= S_BAL1;
          end else if (cur_e.list == LIST_RECENT || cur_e.list == LIST_FREQ) begin
            state <= S_HIT_RES;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_HIT_RES: begin
          if (hit_list == LIST_RECENT) begin
            list_sums[0] <= list_sums[0] - SUM_W'(hit_units);
            list_sums[1] <= list_sums[1] + SUM_W'(hit_units);
          end
          fin_kind  <= KIND_HIT;
          fin_size  <= hit_units;
          touch_ret <= S_FINAL;
          state     <= S_TOUCH;
        end
        S_DIV: begin
          if (div_done) begin
            if (hit_list == LIST_RGHOST) begin
              target_p <= (p_sum < (SUM_W+1)'(capacity)) ? CAP_W'(p_sum) : capacity;
            end else begin
              target_p <= ({1'b0, target_p} > ratio) ? target_p - CAP_W'(ratio) : '0;
            end
            state <= S_GHOST_ADAPT;
          end
        end
        S_GHOST_ADAPT: begin
          list_sums[hit_list] <= list_sums[hit_list] - SUM_W'(hit_units);
          bal_size <= hit_units;
          bal_ret  <= S_GHOST_FIN;
          state    <= S_BAL1;
        end
        S_BAL1: begin
          if (res_total > (SUM_W+1)'(capacity)) begin
            cnt      <= '0;
            scan_ret <= S_BAL1_GOT;
            scan_mode <= SCAN_LRU;
            if (list_sums[0] > SUM_W'(target_p)) begin
              scan_list <= LIST_RECENT;
              state     <= S_SCAN;
            end else if (list_sums[1] != '0) begin
              scan_list <= LIST_FREQ;
              state     <= S_SCAN;
            end else begin
              state <= S_BAL2;
            end
          end else begin
            state <= S_BAL2;
          end
        end
        S_BAL1_GOT: begin
          if (!found) begin
            state <= S_BAL2;
          end else begin
            // move the resident LRU onto its ghost list
            list_sums[cur_e.list]        <= list_sums[cur_e.list] - SUM_W'(cur_e.units);
            list_sums[cur_e.list + 2'd2] <= list_sums[cur_e.list + 2'd2] + SUM_W'(cur_e.units);
            note_kind <= KIND_DEMOTE;
            note_key  <= cur_e.tag;
            note_size <= cur_e.units;
            touch_ret <= S_NOTE;
            state     <= S_TOUCH;
          end
        end
        S_BAL2: begin
          if (ghost_total > (SUM_W+1)'(capacity)) begin
            cnt       <= '0;
            scan_ret  <= S_BAL2_GOT;
            scan_mode <= SCAN_LRU;
            if (list_sums[3] > SUM_W'(target_p)) begin
              scan_list <= LIST_FGHOST;
              state     <= S_SCAN;
            end else if (list_sums[2] != '0) begin
              scan_list <= LIST_RGHOST;
              state     <= S_SCAN;
            end else begin
              cur_idx <= hit_idx;
              state   <= bal_ret;
            end
          end else begin
            cur_idx <= hit_idx;
            state   <= bal_ret;
          end
        end
        S_BAL2_GOT: begin
          if (!found) begin
            cur_idx <= hit_idx;
            state   <= bal_ret;
          end else begin
            list_sums[cur_e.list] <= list_sums[cur_e.list] - SUM_W'(cur_e.units);
            note_kind <= KIND_DROP;
            note_key  <= cur_e.tag;
            note_size <= cur_e.units;
            state     <= S_NOTE;
          end
        end
        S_FREE_START: begin
          scan_mode <= SCAN_FREE;
          cnt       <= '0;
          scan_ret  <= S_FREE_GOT;
          state     <= S_SCAN;
        end
        S_FREE_GOT: begin
          fin_size <= req_size;
          if (!found) begin
            fin_kind <= KIND_FULL;
            state    <= S_FINAL;
          end else if (req_fails) begin
            fin_kind <= KIND_FAIL;
            state    <= S_FINAL;
          end else begin
            list_sums[0] <= list_sums[0] + SUM_W'(req_size);
            fin_kind     <= KIND_MISS;
            touch_ret    <= S_FINAL;
            state        <= S_TOUCH;
          end
        end
        S_GHOST_FIN: begin
          if (req_fails) begin
            list_sums[hit_list] <= list_sums[hit_list] + SUM_W'(hit_units);
            fin_kind <= KIND_FAIL;
          end else begin
            list_sums[1] <= list_sums[1] + SUM_W'(hit_units);
            fin_kind <= (hit_list == LIST_RGHOST) ? KIND_RGHOST : KIND_FGHOST;
          end
          fin_size  <= hit_units;
          touch_ret <= S_FINAL;
          state     <= S_TOUCH;
        end
        S_TOUCH: begin
          if (age_counter == AGE_MAX) begin
            state <= S_RN_CLR;
          end else begin
            age_counter <= age_counter + 1'b1;
            state       <= touch_ret;
          end
        end
        S_RN_CLR: begin
          rn_j  <= '0;
          rn_n  <= '0;
          state <= S_RN_STEP;
        end
        S_RN_STEP: begin
          rn_n <= rn_n + CNT_W'(bc_e.valid);
          rn_j <= rn_j + 1'b1;
          if (rn_j == CNT_W'(ENTRIES - 1)) begin
            state <= S_RN_COMMIT;
          end
        end
        S_RN_COMMIT: begin
          age_counter <= AGE_W'(rn_n);
          state       <= S_TOUCH;
        end
        S_NOTE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= note_kind;
            entry_key     <= 32'(note_key);
            entry_size    <= note_size;
            target_recent <= target_p;
            last          <= 1'b0;
            state         <= (note_kind == KIND_DEMOTE) ? S_BAL1 : S_BAL2;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= fin_kind;
            entry_key     <= 32'(req_key);
            entry_size    <= fin_size;
            target_recent <= target_p;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_target_bounded: assert property (@(posedge clk) disable iff (rst)
    target_p <= capacity)
    else $error("target exceeds capacity");

  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside ratio wait");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free) |=> (state == S_IDLE && out_valid && last))
    else $error("final beat not followed by idle");
`endif

endmodule
